@@ rtl/ptsm_pkg.sv @@
// Package for the periodic transmit slot manager.
// Holds the transaction structs, frame constants and internal control structs.
`timescale 1ns / 1ps

package ptsm_pkg;

    // Frame layout
    localparam int          FRAME_LEN  = 19;
    localparam int          FRAME_W    = FRAME_LEN * 8;
    localparam int          POS_W      = 5;
    localparam logic [4:0]  LAST_POS   = 5'(FRAME_LEN - 1);
    localparam logic [7:0]  FRAME_TAIL = 8'd42;

    // One transmit request
    typedef struct packed {
        logic        [31:0] arb_id;
        logic signed [31:0] period_ms;
        logic        [7:0]  data_size;
        logic        [63:0] payload;
    } t_in_item;

    // One frame byte
    typedef struct packed {
        logic [7:0] frame_byte;
        logic       last;
    } t_out_item;

    // Sequencer to serializer: load a frame
    typedef struct packed {
        logic       start;
        logic [7:0] slot_byte;
    } t_ser_ctl;

    // Serializer to sequencer
    typedef struct packed {
        logic busy;
    } t_ser_sts;

endpackage

@@ rtl/ptsm_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module ptsm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 50
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/ptsm_ser.sv @@
// Frame serializer: loads a 19-byte command frame and shifts it out one byte per transaction.
// Depends on ptsm_pkg.
`timescale 1ns / 1ps

module ptsm_ser (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  ptsm_pkg::t_ser_ctl  i_ctl,
    input  ptsm_pkg::t_in_item  i_item,
    output ptsm_pkg::t_ser_sts  o_sts,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output ptsm_pkg::t_out_item o_out_item
);

    logic [ptsm_pkg::FRAME_W-1:0] r_frame;
    logic [ptsm_pkg::POS_W-1:0]   r_pos;
    logic                         r_valid;
    logic                         out_acc;

    assign out_acc = r_valid && !i_out_stall;

    // Control: valid and byte position
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_pos   <= '0;
        end else if (i_ctl.start) begin
            r_valid <= 1'b1;
            r_pos   <= '0;
        end else if (out_acc) begin
            if (r_pos == ptsm_pkg::LAST_POS) begin
                r_valid <= 1'b0;
            end
            r_pos <= r_pos + 1'b1;
        end
    end

    // Frame shift register, byte 0 in the low bits
    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_frame <= {ptsm_pkg::FRAME_TAIL, i_item.payload, i_item.arb_id,
                        i_item.period_ms, i_ctl.slot_byte, i_item.data_size};
        end else if (out_acc) begin
            r_frame <= {8'd0, r_frame[ptsm_pkg::FRAME_W-1:8]};
        end
    end

    assign o_out_valid           = r_valid;
    assign o_out_item.frame_byte = r_frame[7:0];
    assign o_out_item.last       = (r_pos == ptsm_pkg::LAST_POS);
    assign o_sts.busy            = r_valid;

endmodule

@@ rtl/periodic_tx_slot_manager.sv @@
// Top level of the periodic transmit slot manager: slot table sequencer.
// Depends on ptsm_pkg, ptsm_ram and ptsm_ser.
//
//   channel | direction | handshake               | payload
//   --------+-----------+-------------------------+----------------------------
//   in      | input     | i_in_valid / o_in_stall | i_in_item  (ptsm_pkg::t_in_item)
//   out     | output    | o_out_valid/ i_out_stall| o_out_item (ptsm_pkg::t_out_item)
//
// One request walks the owner table one slot per cycle through the owner RAM's single
// read port and one 32-bit comparator, ending early on a match.
// The frame then goes out at one byte per cycle while the output does not stall; the
// block is ready again once the serializer's busy flag drops and the state goes idle.
// A full table drops the request and returns to ready right after the scan.
// Reset is synchronous; it clears the used flags, so no clearing pass is needed.
// Output stalls hold the current byte and delay the return to ready.
`timescale 1ns / 1ps

module periodic_tx_slot_manager #(
    parameter int SLOTS = 50
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  ptsm_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output ptsm_pkg::t_out_item o_out_item
);

    localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW = $clog2(SLOTS + 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_EMIT = 2'd2;

    logic [1:0]         r_state,   n_state;
    ptsm_pkg::t_in_item r_item,    n_item;
    logic [CW-1:0]      r_cnt,     n_cnt;
    logic               r_pend,    n_pend;
    logic [SW-1:0]      r_pidx,    n_pidx;
    logic               r_free_ok, n_free_ok;
    logic [SW-1:0]      r_free,    n_free;
    logic [SLOTS-1:0]   r_used,    n_used;

    logic               in_acc;
    logic               issue;
    logic [31:0]        rd_owner;
    logic               cmp_hit;
    logic               cur_free;
    logic               scan_end;
    logic               sel_free_ok;
    logic [SW-1:0]      sel_free;
    logic               positive;
    logic               ram_we;
    logic [SW-1:0]      ram_waddr;
    logic [SW-1:0]      ram_raddr;
    logic [SW-1:0]      ser_slot;
    ptsm_pkg::t_ser_ctl ser_ctl;
    ptsm_pkg::t_ser_sts ser_sts;

    assign o_in_stall = (r_state != S_IDLE) || !i_rst_n;
    assign in_acc     = i_in_valid && !o_in_stall;

    // Scan datapath: one owner compare per cycle
    assign issue       = (r_cnt < CW'(SLOTS));
    assign ram_raddr   = r_cnt[SW-1:0];
    assign cmp_hit     = r_pend && r_used[r_pidx] && (rd_owner == r_item.arb_id);
    assign cur_free    = r_pend && !r_used[r_pidx];
    assign scan_end    = r_pend && (cmp_hit || (r_pidx == SW'(SLOTS - 1)));
    assign sel_free_ok = r_free_ok || cur_free;
    assign sel_free    = r_free_ok ? r_free : r_pidx;
    assign positive    = !r_item.period_ms[31] && (r_item.period_ms != '0);
    assign ram_waddr   = sel_free;

    // Sequencer
    always_comb begin
        n_state   = r_state;
        n_item    = r_item;
        n_cnt     = r_cnt;
        n_pend    = r_pend;
        n_pidx    = r_pidx;
        n_free_ok = r_free_ok;
        n_free    = r_free;
        n_used    = r_used;
        ram_we    = 1'b0;
        ser_slot  = cmp_hit ? r_pidx : sel_free;
        ser_ctl.start     = 1'b0;
        ser_ctl.slot_byte = {{(8 - SW){1'b0}}, ser_slot};
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_item    = i_in_item;
                    n_cnt     = '0;
                    n_pend    = 1'b0;
                    n_free_ok = 1'b0;
                    n_state   = S_SCAN;
                end
            end
            S_SCAN: begin
                // issue the next owner read
                n_pend = issue;
                if (issue) begin
                    n_pidx = r_cnt[SW-1:0];
                    n_cnt  = r_cnt + 1'b1;
                end
                // remember the lowest free slot
                if (cur_free && !r_free_ok) begin
                    n_free_ok = 1'b1;
                    n_free    = r_pidx;
                end
                if (scan_end) begin
                    n_pend = 1'b0;
                    if (cmp_hit) begin
                        // known id: keep or release its slot
                        if (!positive) begin
                            n_used[r_pidx] = 1'b0;
                        end
                        ser_ctl.start = 1'b1;
                        n_state       = S_EMIT;
                    end else if (sel_free_ok) begin
                        // unknown id: claim the lowest free slot
                        ram_we           = 1'b1;
                        n_used[sel_free] = 1'b1;
                        ser_ctl.start    = 1'b1;
                        n_state          = S_EMIT;
                    end else begin
                        // table full: drop the request
                        n_state = S_IDLE;
                    end
                end
            end
            S_EMIT: begin
                if (!ser_sts.busy) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_pend    <= 1'b0;
            r_free_ok <= 1'b0;
            r_cnt     <= '0;
            r_used    <= '0;
        end else begin
            r_state   <= n_state;
            r_pend    <= n_pend;
            r_free_ok <= n_free_ok;
            r_cnt     <= n_cnt;
            r_used    <= n_used;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_item <= n_item;
        r_pidx <= n_pidx;
        r_free <= n_free;
    end

    // Owner table
    ptsm_ram #(
        .WIDTH (32),
        .DEPTH (SLOTS)
    ) u_owner_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (r_item.arb_id),
        .i_raddr (ram_raddr),
        .o_rdata (rd_owner)
    );

    // Frame serializer
    ptsm_ser u_ser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (ser_ctl),
        .i_item      (r_item),
        .o_sts       (ser_sts),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

endmodule

@@ rtl/ptsm_checker.sv @@
// Port-level checker for the periodic transmit slot manager, bound to the top level.
// Depends on ptsm_pkg.
`timescale 1ns / 1ps

module ptsm_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_stall,
    input logic                o_out_valid,
    input logic                i_out_stall,
    input ptsm_pkg::t_out_item o_out_item
);

    // Hold a stalled output byte
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_item))
        else $error("stalled output byte changed");

    // Block is busy right after taking a request
    a_busy_after_acc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("request taken while previous one in progress");

    // No request is taken while a frame is going out
    a_no_acc_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_in_stall)
        else $error("input ready during frame output");

    // Frame bytes follow back to back until the last one
    a_frame_cont: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_stall && !o_out_item.last |=> o_out_valid)
        else $error("frame cut short");

    // Last byte carries the tail constant
    a_tail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.last |-> o_out_item.frame_byte == ptsm_pkg::FRAME_TAIL)
        else $error("last byte is not the frame tail");

endmodule

bind periodic_tx_slot_manager ptsm_checker u_ptsm_checker (.*);
